// ----- src/clcd_pkg.sv -----
// ----------------------------------------------------------------------------
// Character LCD controller package
// Shared codes, constants, tables and types of the 4-bit LCD controller.
// ----------------------------------------------------------------------------
package clcd_pkg;

	// Request codes on the cmd input.
	localparam logic [2:0] CMD_COMMAND = 3'd0;
	localparam logic [2:0] CMD_DATA    = 3'd1;
	localparam logic [2:0] CMD_CURSOR  = 3'd2;
	localparam logic [2:0] CMD_NUMBER  = 3'd3;
	localparam logic [2:0] CMD_INIT    = 3'd4;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_HOLD = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_POWER_WAIT = 1'b1;

	localparam logic [7:0] PULSE_HOLD_RESET = 8'd30;
	localparam logic [7:0] POWER_WAIT_RESET = 8'd35;

	// Decimal conversion sizes.
	localparam int NUM_W      = 32;
	localparam int BCD_DIGITS = 10;
	localparam int BCD_W      = 4 * BCD_DIGITS;
	localparam int BIT_CNT_W  = $clog2(NUM_W);
	localparam int DIG_CNT_W  = $clog2(BCD_DIGITS + 1);

	localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;
	localparam logic [7:0] CURSOR_SET     = 8'h80;
	localparam logic [2:0] INIT_STEPS     = 3'd5;

	// DDRAM address of the first column of each display row.
	function automatic logic [7:0] row_base(input logic [1:0] row);
		logic [7:0] base;
		case (row)
			2'd0:    base = 8'h00;
			2'd1:    base = 8'h40;
			2'd2:    base = 8'h14;
			default: base = 8'h54;
		endcase
		return base;
	endfunction

	// Power-up command sequence: home, 4-bit two-line, display on,
	// clear, entry mode increment.
	function automatic logic [7:0] init_cmd(input logic [2:0] idx);
		logic [7:0] code;
		case (idx)
			3'd0:    code = 8'h02;
			3'd1:    code = 8'b0010_1000;
			3'd2:    code = 8'b0000_1100;
			3'd3:    code = 8'h01;
			default: code = 8'h06;
		endcase
		return code;
	endfunction

	// Settling time in ms added after each power-up command.
	function automatic logic [1:0] init_delay(input logic [2:0] idx);
		logic [1:0] dly;
		case (idx)
			3'd0:    dly = 2'd2;
			3'd3:    dly = 2'd2;
			default: dly = 2'd1;
		endcase
		return dly;
	endfunction

	// One byte (or one idle wait) handed to the nibble transmitter.
	typedef struct packed {
		logic       wait_only;
		logic       rs;
		logic [7:0] data;
		logic [1:0] post_delay;
		logic       last;
	} tx_req_t;

	// One pin-state event.
	typedef struct packed {
		logic       rs;
		logic [3:0] nibble;
		logic       enable;
		logic [8:0] hold;
		logic       last;
	} pin_event_t;

endpackage

// ----- src/clcd_bcd.sv -----
// ----------------------------------------------------------------------------
// Bit-serial binary to BCD converter
// Shift-and-add-3 conversion, one binary bit per clock.
// ----------------------------------------------------------------------------
module clcd_bcd (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [clcd_pkg::NUM_W-1:0]    value,
	output logic                          done,
	output logic [clcd_pkg::BCD_W-1:0]    bcd
);

	logic                              run_q;
	logic                              done_q;
	logic [clcd_pkg::BIT_CNT_W-1:0]    cnt_q;
	logic [clcd_pkg::NUM_W-1:0]        bin_q;
	logic [clcd_pkg::BCD_W-1:0]        bcd_q;
	logic [clcd_pkg::BCD_W-1:0]        adj;

	// Every digit of five or more gets three added before the next shift.
	always_comb begin
		for (int d = 0; d < clcd_pkg::BCD_DIGITS; d++) begin
			adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ? bcd_q[4*d +: 4] + 4'd3
			                                          : bcd_q[4*d +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				bin_q <= value;
				bcd_q <= '0;
			end else if (run_q) begin
				bcd_q <= {adj[clcd_pkg::BCD_W-2:0], bin_q[clcd_pkg::NUM_W-1]};
				bin_q <= {bin_q[clcd_pkg::NUM_W-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == clcd_pkg::BIT_CNT_W'(clcd_pkg::NUM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ----- src/clcd_byte_tx.sv -----
// ----------------------------------------------------------------------------
// Nibble transmitter
// Turns one byte into four enable-pulse events, or emits one idle wait.
// ----------------------------------------------------------------------------
module clcd_byte_tx (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  clcd_pkg::tx_req_t       req,
	input  logic [7:0]              pulse_hold,
	input  logic [7:0]              power_wait,
	output logic                    ready,
	output logic                    ev_strobe,
	output clcd_pkg::pin_event_t    ev
);

	logic                    active_q;
	logic [1:0]              phase_q;
	logic                    strobe_q;
	clcd_pkg::tx_req_t       req_q;
	clcd_pkg::pin_event_t    ev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (active_q) begin
				phase_q <= phase_q + 2'd1;
				if (req_q.wait_only) begin
					ev_q.rs     <= 1'b0;
					ev_q.nibble <= '0;
					ev_q.enable <= 1'b0;
					ev_q.hold   <= {1'b0, power_wait};
					ev_q.last   <= req_q.last;
					active_q    <= 1'b0;
				end else begin
					// Phases: high nibble with E high, E low, then low nibble the same.
					ev_q.rs     <= req_q.rs;
					ev_q.nibble <= phase_q[1] ? req_q.data[3:0] : req_q.data[7:4];
					ev_q.enable <= ~phase_q[0];
					if (phase_q == 2'd3) begin
						ev_q.hold <= {1'b0, pulse_hold} + {7'd0, req_q.post_delay};
						ev_q.last <= req_q.last;
						active_q  <= 1'b0;
					end else begin
						ev_q.hold <= {1'b0, pulse_hold};
						ev_q.last <= 1'b0;
					end
				end
			end else if (req_valid) begin
				req_q    <= req;
				active_q <= 1'b1;
				phase_q  <= '0;
			end
		end
	end

	assign ready     = ~active_q;
	assign ev_strobe = strobe_q;
	assign ev        = ev_q;

endmodule

// ----- src/char_lcd_four_bit_controller.sv -----
// ----------------------------------------------------------------------------
// Character LCD controller, 4-bit bus
// Turns requests into timed pin-state events for an HD44780-style display.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                       Transfer
// request   start, busy, cmd, byte_value, row, column,    start high, busy low
//           number
// event     result_strobe, rs_pin, data_nibble,           result_strobe high,
//           enable_pin, hold_ms, last                     one cycle each
// config    cfg_write, cfg_index, cfg_data                cfg_write high
//
// A command or data byte, and a cursor move, are handed to the nibble
// transmitter, which sends four events at one per cycle through one output
// register. A decimal number first runs the bit-serial BCD converter, then
// drops leading zeros one digit per cycle and sends each remaining digit
// as an ASCII byte. The nibble transmitter, which accepts a new byte only
// after its fourth event, sets the event rate. Reset clears both
// configuration registers to their defaults and leaves the block idle.
// Events cannot be stalled.
//
module char_lcd_four_bit_controller (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [2:0]                           cmd,
	input  logic [7:0]                           byte_value,
	input  logic [7:0]                           row,
	input  logic [7:0]                           column,
	input  logic [31:0]                          number,
	input  logic                                 cfg_write,
	input  logic [clcd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [7:0]                           cfg_data,
	output logic                                 result_strobe,
	output logic                                 rs_pin,
	output logic [3:0]                           data_nibble,
	output logic                                 enable_pin,
	output logic [8:0]                           hold_ms,
	output logic                                 last
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ONE,
		S_CONV,
		S_SKIP,
		S_DIGITS,
		S_INIT
	} state_t;

	state_t                              state_q;
	logic [7:0]                          pulse_hold_q;
	logic [7:0]                          power_wait_q;
	logic                                one_rs_q;
	logic [7:0]                          one_data_q;
	logic [clcd_pkg::BCD_W-1:0]          digits_q;
	logic [clcd_pkg::DIG_CNT_W-1:0]      dig_cnt_q;
	logic [2:0]                          step_q;

	logic                                accept;
	logic                                conv_start;
	logic                                conv_done;
	logic [clcd_pkg::BCD_W-1:0]          conv_bcd;
	logic                                tx_req_valid;
	clcd_pkg::tx_req_t                   tx_req;
	logic                                tx_ready;
	logic                                issue;
	logic                                ev_strobe;
	clcd_pkg::pin_event_t                ev;
	logic [3:0]                          top_digit;

	assign busy       = (state_q != S_IDLE) | ~tx_ready;
	assign accept     = start & ~busy;
	assign conv_start = accept & (cmd == clcd_pkg::CMD_NUMBER);
	assign top_digit  = digits_q[clcd_pkg::BCD_W-1 -: 4];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_hold_q <= clcd_pkg::PULSE_HOLD_RESET;
			power_wait_q <= clcd_pkg::POWER_WAIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				clcd_pkg::REG_PULSE_HOLD: pulse_hold_q <= cfg_data;
				clcd_pkg::REG_POWER_WAIT: power_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The byte offered to the transmitter depends only on the current state.
	always_comb begin
		tx_req       = '0;
		tx_req_valid = 1'b0;
		case (state_q)
			S_ONE: begin
				tx_req_valid = 1'b1;
				tx_req.rs    = one_rs_q;
				tx_req.data  = one_data_q;
				tx_req.last  = 1'b1;
			end
			S_DIGITS: begin
				tx_req_valid = 1'b1;
				tx_req.rs    = 1'b1;
				tx_req.data  = {clcd_pkg::ASCII_DIGIT_HI, top_digit};
				tx_req.last  = (dig_cnt_q == clcd_pkg::DIG_CNT_W'(1));
			end
			S_INIT: begin
				tx_req_valid = 1'b1;
				if (step_q == 3'd0) begin
					// The power-on wait comes before the first command.
					tx_req.wait_only = 1'b1;
				end else begin
					tx_req.data       = clcd_pkg::init_cmd(step_q - 3'd1);
					tx_req.post_delay = clcd_pkg::init_delay(step_q - 3'd1);
				end
				tx_req.last = (step_q == clcd_pkg::INIT_STEPS);
			end
			default: ;
		endcase
	end

	assign issue = tx_req_valid & tx_ready;

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dig_cnt_q <= '0;
			step_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							clcd_pkg::CMD_COMMAND: begin
								one_rs_q   <= 1'b0;
								one_data_q <= byte_value;
								state_q    <= S_ONE;
							end
							clcd_pkg::CMD_DATA: begin
								one_rs_q   <= 1'b1;
								one_data_q <= byte_value;
								state_q    <= S_ONE;
							end
							clcd_pkg::CMD_CURSOR: begin
								// Rows past the fourth produce no events at all.
								if (row <= 8'd3) begin
									one_rs_q   <= 1'b0;
									one_data_q <= clcd_pkg::CURSOR_SET
									              + clcd_pkg::row_base(row[1:0]) + column;
									state_q    <= S_ONE;
								end
							end
							clcd_pkg::CMD_NUMBER: begin
								state_q <= S_CONV;
							end
							clcd_pkg::CMD_INIT: begin
								step_q  <= '0;
								state_q <= S_INIT;
							end
							default: ;
						endcase
					end
				end
				S_ONE: begin
					if (issue) begin
						state_q <= S_IDLE;
					end
				end
				S_CONV: begin
					if (conv_done) begin
						digits_q  <= conv_bcd;
						dig_cnt_q <= clcd_pkg::DIG_CNT_W'(clcd_pkg::BCD_DIGITS);
						state_q   <= S_SKIP;
					end
				end
				S_SKIP: begin
					// Leading zeros are dropped, but the ones digit is always sent.
					if (top_digit == 4'd0 && dig_cnt_q > clcd_pkg::DIG_CNT_W'(1)) begin
						digits_q  <= {digits_q[clcd_pkg::BCD_W-5:0], 4'd0};
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else begin
						state_q <= S_DIGITS;
					end
				end
				S_DIGITS: begin
					if (issue) begin
						digits_q  <= {digits_q[clcd_pkg::BCD_W-5:0], 4'd0};
						dig_cnt_q <= dig_cnt_q - 1'b1;
						if (dig_cnt_q == clcd_pkg::DIG_CNT_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_INIT: begin
					if (issue) begin
						step_q <= step_q + 3'd1;
						if (step_q == clcd_pkg::INIT_STEPS) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	clcd_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (conv_start),
		.value  (number),
		.done   (conv_done),
		.bcd    (conv_bcd)
	);

	clcd_byte_tx u_byte_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (tx_req_valid),
		.req        (tx_req),
		.pulse_hold (pulse_hold_q),
		.power_wait (power_wait_q),
		.ready      (tx_ready),
		.ev_strobe  (ev_strobe),
		.ev         (ev)
	);

	assign result_strobe = ev_strobe;
	assign rs_pin        = ev.rs;
	assign data_nibble   = ev.nibble;
	assign enable_pin    = ev.enable;
	assign hold_ms       = ev.hold;
	assign last          = ev.last;

	// A byte request keeps the block busy until its events are out.
	a_busy_after_byte: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd == clcd_pkg::CMD_COMMAND || cmd == clcd_pkg::CMD_DATA) |=> busy)
		else $error("busy dropped after a byte request");

	// An event seen while the block is idle must close its request.
	a_idle_event_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !busy |-> last)
		else $error("non-final event while idle");

	// The final event of a request is never followed at once by another event.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |=> !result_strobe)
		else $error("event directly after a final event");

	// Digit sending always has at least one digit left.
	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGITS || state_q == S_SKIP) |-> dig_cnt_q != '0)
		else $error("digit counter ran empty");

endmodule
